[sv/dsdp_pkg.sv]
// Package for the delta-sigma dithered PWM duty block.
// Holds the sequencer state type, register indexes, reset values and other constants.
// No dependencies.
package dsdp_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_RATIO,
      ST_BASE,
      ST_DIV_LOAD,
      ST_DIV_STEP,
      ST_MUL_REM,
      ST_FRACTION
   } seq_state_type;

   typedef enum logic {
      REG_PERIOD = 1'b0,
      REG_RATIO  = 1'b1
   } reg_index_type;

   localparam logic [15:0] RESET_PERIOD    = 16'h9600;
   localparam logic [31:0] RESET_RATIO     = 32'd3053247871;
   localparam logic [15:0] MIN_PERIOD      = 16'd16;
   localparam logic [15:0] PERIOD_LOW_MASK = 16'h0007;
   localparam logic [31:0] FULL_SCALE      = 32'hFFFF_FFFF;

endpackage

[sv/delta_sigma_dithered_pwm_duty.sv]
// Top level of the delta-sigma dithered PWM duty block.
// Uses dsdp_pkg for the sequencer state type, register indexes and constants.
//
// Every item gives one result: the compare value (base count plus the dither bit), the
// period reload and the dither bit, where an item with advance set first steps the
// first-order accumulator. While the block is idle an item is taken and its result is
// registered, so items can follow one another every cycle as long as the result side
// keeps up. After reset and after every register write the block recomputes the
// base count and fractional step on one shared 32 by 16 bit multiplier and a
// one-bit-per-cycle divider (two multiplies, base correction, divider load, 32
// divider steps and scaling); req_ready stays low while that sequence runs.
module delta_sigma_dithered_pwm_duty #(
   parameter int ACC_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_advance,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_compare_value,
   output logic [15:0] rsp_period_reload,
   output logic        rsp_dither_bit,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import dsdp_pkg::*;

   localparam int FRAC_WIDTH = ACC_WIDTH - 2;
   localparam int SHR        = (ACC_WIDTH <= 34) ? 34 - ACC_WIDTH : 0;
   localparam int SHL        = (ACC_WIDTH > 34) ? ACC_WIDTH - 34 : 0;
   localparam logic [ACC_WIDTH-1:0] ACC_TOP = {1'b1, {(ACC_WIDTH-1){1'b0}}};
   localparam logic [ACC_WIDTH-1:0] ACC_SUB = {2'b11, {(ACC_WIDTH-2){1'b0}}};

   seq_state_type             state_ff, state_in;
   logic [15:0]               period_ff, period_in;
   logic [31:0]               ratio_ff, ratio_in;
   logic [47:0]               prod_ff, prod_in;
   logic [15:0]               base_ff, base_in;
   logic [15:0]               div_rem_ff, div_rem_in;
   logic [31:0]               div_quo_ff, div_quo_in;
   logic [4:0]                div_cnt_ff, div_cnt_in;
   logic [FRAC_WIDTH-1:0]     frac_ff, frac_in;
   logic [ACC_WIDTH-1:0]      acc_ff, acc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [15:0]               rsp_compare_ff, rsp_compare_in;
   logic [15:0]               rsp_reload_ff, rsp_reload_in;
   logic                      rsp_dither_ff, rsp_dither_in;

   logic                      cfg_write;
   reg_index_type             cfg_index;
   logic [15:0]               eff_period;
   logic [31:0]               mul_a;
   logic [32:0]               base_sum;
   logic [47:0]               dividend;
   logic [16:0]               div_trial;
   logic                      div_ge;
   logic [31:0]               rem_sat;
   logic [ACC_WIDTH+29:0]     frac_wide;
   logic                      req_fire;
   logic [ACC_WIDTH-1:0]      acc_step;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite & pready;
   assign cfg_index = reg_index_type'(paddr[2]);
   assign prdata    = (cfg_index == REG_RATIO) ? ratio_ff : {16'd0, period_ff};

   always_comb begin
      eff_period = (period_ff < MIN_PERIOD) ? MIN_PERIOD : period_ff;
      eff_period = eff_period & ~PERIOD_LOW_MASK;
   end

   always_comb begin
      period_in = period_ff;
      ratio_in  = ratio_ff;
      if (cfg_write) begin
         unique case (cfg_index)
            REG_PERIOD: period_in = pwdata[15:0];
            REG_RATIO:  ratio_in  = pwdata;
            default:    period_in = period_ff;
         endcase
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      state_in = ST_IDLE;
         ST_MUL_RATIO: state_in = ST_BASE;
         ST_BASE:      state_in = ST_DIV_LOAD;
         ST_DIV_LOAD:  state_in = ST_DIV_STEP;
         ST_DIV_STEP:  state_in = (div_cnt_ff == 5'd31) ? ST_MUL_REM : ST_DIV_STEP;
         ST_MUL_REM:   state_in = ST_FRACTION;
         ST_FRACTION:  state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
      if (cfg_write) begin
         state_in = ST_MUL_RATIO;
      end
   end

   // Shared datapath, steered by the sequencer state.
   always_comb begin
      mul_a      = (state_ff == ST_MUL_REM) ? (ratio_ff - div_quo_ff) : ratio_ff;
      base_sum   = {1'b0, prod_ff[31:0]} + 33'(prod_ff[47:32]);
      dividend   = {base_ff, 32'd0} - 48'(base_ff);
      div_trial  = {div_rem_ff, div_quo_ff[31]};
      div_ge     = (div_trial >= 17'(eff_period));
      rem_sat    = (prod_ff[47:32] != 16'd0) ? FULL_SCALE : prod_ff[31:0];
      frac_wide  = ((ACC_WIDTH+30)'(rem_sat) << SHL) >> SHR;

      prod_in    = prod_ff;
      base_in    = base_ff;
      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      div_cnt_in = div_cnt_ff;
      frac_in    = frac_ff;
      unique case (state_ff)
         ST_MUL_RATIO, ST_MUL_REM: begin
            prod_in = 48'(mul_a) * 48'(eff_period);
         end
         ST_BASE: begin
            base_in = prod_ff[47:32] + 16'(base_sum >= {1'b0, FULL_SCALE});
         end
         ST_DIV_LOAD: begin
            div_rem_in = dividend[47:32];
            div_quo_in = dividend[31:0];
            div_cnt_in = 5'd0;
         end
         ST_DIV_STEP: begin
            div_rem_in = div_ge ? 16'(div_trial - 17'(eff_period)) : div_trial[15:0];
            div_quo_in = {div_quo_ff[30:0], div_ge};
            div_cnt_in = div_cnt_ff + 5'd1;
         end
         ST_FRACTION: begin
            frac_in = frac_wide[FRAC_WIDTH-1:0];
         end
         default: begin
            prod_in = prod_ff;
         end
      endcase
   end

   // Handshake and modulator step.
   always_comb begin
      req_ready      = (state_ff == ST_IDLE) & (~rsp_valid_ff | rsp_ready);
      req_fire       = req_valid & req_ready;
      acc_step       = acc_ff + ACC_WIDTH'(frac_ff) + (acc_ff[ACC_WIDTH-1] ? ACC_SUB : '0);
      acc_in         = (req_fire & req_advance) ? acc_step : acc_ff;
      rsp_valid_in   = req_fire | (rsp_valid_ff & ~rsp_ready);
      rsp_dither_in  = req_fire ? acc_in[ACC_WIDTH-1] : rsp_dither_ff;
      rsp_compare_in = req_fire ? base_ff + 16'(acc_in[ACC_WIDTH-1]) : rsp_compare_ff;
      rsp_reload_in  = req_fire ? eff_period - 16'd1 : rsp_reload_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_MUL_RATIO;
         period_ff    <= RESET_PERIOD;
         ratio_ff     <= RESET_RATIO;
         acc_ff       <= ACC_TOP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         ratio_ff     <= ratio_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff        <= prod_in;
      base_ff        <= base_in;
      div_rem_ff     <= div_rem_in;
      div_quo_ff     <= div_quo_in;
      div_cnt_ff     <= div_cnt_in;
      frac_ff        <= frac_in;
      rsp_compare_ff <= rsp_compare_in;
      rsp_reload_ff  <= rsp_reload_in;
      rsp_dither_ff  <= rsp_dither_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_compare_value = rsp_compare_ff;
   assign rsp_period_reload = rsp_reload_ff;
   assign rsp_dither_bit    = rsp_dither_ff;

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("Item accepted while the recompute sequence is running.");

   a_write_restarts: assert property (@(posedge clock) disable iff (reset)
      cfg_write |=> (state_ff == ST_MUL_RATIO))
      else $error("Register write did not restart the recompute sequence.");

   a_divider_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_STEP && div_cnt_ff == 5'd31 && !cfg_write)
      |=> (state_ff == ST_MUL_REM))
      else $error("Divider did not finish after its last step.");

   a_report_keeps_acc: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_advance) |=> $stable(acc_ff))
      else $error("Report-only item changed the accumulator.");

   a_base_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (base_ff <= eff_period))
      else $error("Base count exceeds the effective period.");

endmodule
